// ===== rtl/core/scld_pkg.sv =====
// shared types and constants for the serial command line decoder
package scld_pkg;

   localparam int unsigned CmdW  = 4;
   localparam int unsigned SpdW  = 16;
   localparam int unsigned DistW = 24;
   localparam int unsigned ProfW = 2;

   typedef enum logic [CmdW-1:0] {
      CMD_PING    = 4'd0,
      CMD_CAL     = 4'd1,
      CMD_HOME    = 4'd2,
      CMD_JSTOP   = 4'd3,
      CMD_STOP    = 4'd4,
      CMD_ESTOP   = 4'd5,
      CMD_ECLR    = 4'd6,
      CMD_JOG     = 4'd7,
      CMD_MOVE    = 4'd8,
      CMD_PROFILE = 4'd9
   } cmd_type;

   localparam logic [ProfW-1:0] PROF_LIN  = 2'd0;
   localparam logic [ProfW-1:0] PROF_TRAP = 2'd1;
   localparam logic [ProfW-1:0] PROF_SIN  = 2'd2;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_LO    = 8'h20;
   localparam logic [7:0] CH_HI    = 8'h7E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_F     = 8'h46;

   // classified byte handed from front to back
   typedef enum logic [1:0] {
      EV_CHAR  = 2'd0,
      EV_EOL   = 2'd1,
      EV_CLEAR = 2'd2
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  ch;
   } ev_type;

   // parse phase of the back end
   typedef enum logic [2:0] {
      PH_KEY, PH_SEEK1, PH_TOK1, PH_SEEK2, PH_TOK2, PH_DONE
   } phase_type;

   // number sub-phase within a token
   typedef enum logic [2:0] {
      NS_LEAD, NS_INT, NS_FRAC1, NS_FRAC2, NS_STOP
   } num_type;

   typedef struct packed {
      cmd_type          command;
      logic             jog_forward;
      logic [SpdW-1:0]  speed_value;
      logic [DistW-1:0] distance_centi_cm;
      logic [ProfW-1:0] profile_select;
   } rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

// ===== rtl/core/scld_front.sv =====
// front end: filters bytes, tracks line length and overflow
module scld_front #(
   parameter int unsigned LINE_CAP = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   output logic                ev_valid,
   input  logic                ev_ready,
   output scld_pkg::ev_type    ev_data
);
   import scld_pkg::*;

   localparam int unsigned LenW = $clog2(LINE_CAP + 1);

   logic [LenW-1:0] len_ff, len_in;
   logic            printable;

   assign in_ready  = ev_ready;
   assign printable = (in_byte >= CH_LO) && (in_byte <= CH_HI);

   always_comb begin
      len_in        = len_ff;
      ev_valid      = 1'b0;
      ev_data.kind  = EV_CHAR;
      ev_data.ch    = in_byte;
      if (in_valid) begin
         if (in_byte == CH_NL) begin
            ev_valid     = 1'b1;
            ev_data.kind = (len_ff != '0) ? EV_EOL : EV_CLEAR;
            len_in       = '0;
         end else if (printable) begin
            ev_valid = 1'b1;
            if (len_ff < LenW'(LINE_CAP)) begin
               len_in = len_ff + 1'b1;
            end else begin
               ev_data.kind = EV_CLEAR;
               len_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (in_valid && in_ready) begin
         len_ff <= len_in;
      end
   end

endmodule

// ===== rtl/core/scld_fifo.sv =====
// short queue between front and back
module scld_fifo #(
   parameter int unsigned WIDTH = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end

endmodule

// ===== rtl/core/scld_back.sv =====
// back end: incremental parse of each line, result register
module scld_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                ev_valid,
   output logic                ev_ready,
   input  scld_pkg::ev_type    ev_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output scld_pkg::rsp_type   rsp_data
);
   import scld_pkg::*;

   // key state
   logic [7:0] key_ff [8];
   logic [7:0] key_in [8];
   logic [3:0] klen_ff, klen_in;
   logic       klong_ff, klong_in;
   phase_type  ph_ff, ph_in;
   // args
   logic       fwd_ff, fwd_in;
   num_type    ns1_ff, ns1_in, ns2_ff, ns2_in;
   logic       neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic [16:0] whole_ff, whole_in;
   logic [6:0]  frac_ff, frac_in;
   logic [15:0] spd_ff, spd_in;
   // profile argument match: length seen and prefix flags
   logic [2:0] pcnt_ff, pcnt_in;
   logic       plin_ff, plin_in, psin_ff, psin_in, pover_ff, pover_in;

   logic       out_v_ff;
   rsp_type    out_ff, res;
   logic       take, fire;

   // only an item that completes a command waits for the result register
   assign ev_ready  = !out_v_ff || rsp_ready || !fire;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign take      = ev_valid && ev_ready;

   function automatic logic key_is(input logic [7:0] k [8], input logic [3:0] n,
                                   input logic [63:0] w, input logic [3:0] wl);
      logic ok;
      ok = (n == wl);
      for (int i = 0; i < 8; i++) begin
         if (i < wl && k[i] != w[63-8*i -: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   logic k_ping, k_cal, k_home, k_jstop, k_stop, k_estop, k_eclr;
   logic k_jog, k_move, k_prof;
   always_comb begin
      k_ping  = !klong_ff && key_is(key_ff, klen_ff, {"PING", 32'h0}, 4'd4);
      k_cal   = !klong_ff && key_is(key_ff, klen_ff, {"CAL", 40'h0}, 4'd3);
      k_home  = !klong_ff && key_is(key_ff, klen_ff, {"HOME", 32'h0}, 4'd4);
      k_jstop = !klong_ff && key_is(key_ff, klen_ff, {"JSTOP", 24'h0}, 4'd5);
      k_stop  = !klong_ff && key_is(key_ff, klen_ff, {"STOP", 32'h0}, 4'd4);
      k_estop = !klong_ff && key_is(key_ff, klen_ff, {"ESTOP", 24'h0}, 4'd5);
      k_eclr  = !klong_ff && key_is(key_ff, klen_ff, {"ECLR", 32'h0}, 4'd4);
      k_jog   = !klong_ff && key_is(key_ff, klen_ff, {"JOG", 40'h0}, 4'd3);
      k_move  = !klong_ff && key_is(key_ff, klen_ff, {"MOVE", 32'h0}, 4'd4);
      k_prof  = !klong_ff && key_is(key_ff, klen_ff, {"PROFILE", 8'h0}, 4'd7);
   end

   logic [7:0]  c;
   logic [3:0]  dg;
   logic [20:0] wmul;
   logic [19:0] smul;
   logic [23:0] centi, dist_val;
   logic [16:0] sp_mag;
   logic        dig;
   logic        in_args;

   assign in_args = ph_ff != PH_KEY;

   // next state
   always_comb begin
      c    = ev_data.ch;
      dg   = c[3:0];
      dig  = is_digit(c);
      wmul = 21'(whole_ff) * 21'd10 + 21'(dg);
      smul = 20'(spd_ff) * 20'd10 + 20'(dg);
      for (int i = 0; i < 8; i++) key_in[i] = key_ff[i];
      klen_in  = klen_ff;  klong_in = klong_ff; ph_in = ph_ff;
      fwd_in   = fwd_ff;   ns1_in = ns1_ff;     ns2_in = ns2_ff;
      neg1_in  = neg1_ff;  neg2_in = neg2_ff;
      whole_in = whole_ff; frac_in = frac_ff;   spd_in = spd_ff;
      pcnt_in  = pcnt_ff;  plin_in = plin_ff;   psin_in = psin_ff;
      pover_in = pover_ff;

      if (ev_data.kind == EV_CHAR) begin
         unique case (ph_ff)
            PH_KEY: begin
               if (c == CH_COLON) begin
                  ph_in = PH_SEEK1;
               end else if (klen_ff == 4'd8 || klong_ff) begin
                  klong_in = 1'b1;
               end else begin
                  key_in[klen_ff[2:0]] = c;
                  klen_in = klen_ff + 4'd1;
               end
            end
            PH_SEEK1, PH_TOK1: begin
               if (c == CH_COMMA) begin
                  if (ph_ff == PH_TOK1) ph_in = PH_SEEK2;
               end else begin
                  if (ph_ff == PH_SEEK1) fwd_in = (c == CH_F);
                  ph_in = PH_TOK1;
                  unique case (ns1_ff)
                     NS_LEAD: begin
                        if (c == CH_SPACE) ns1_in = NS_LEAD;
                        else if (c == CH_PLUS || c == CH_MINUS) begin
                           neg1_in = c == CH_MINUS; ns1_in = NS_INT;
                        end else if (dig) begin
                           whole_in = 17'(wmul); ns1_in = NS_INT;
                        end else if (c == CH_DOT) ns1_in = NS_FRAC1;
                        else ns1_in = NS_STOP;
                     end
                     NS_INT: begin
                        if (dig) whole_in = (wmul > 21'd100000) ? 17'd100000 : 17'(wmul);
                        else if (c == CH_DOT) ns1_in = NS_FRAC1;
                        else ns1_in = NS_STOP;
                     end
                     NS_FRAC1: begin
                        if (dig) begin
                           frac_in = 7'(dg) * 7'd10; ns1_in = NS_FRAC2;
                        end else ns1_in = NS_STOP;
                     end
                     NS_FRAC2: begin
                        if (dig) frac_in = frac_ff + 7'(dg);
                        ns1_in = NS_STOP;
                     end
                     default: ns1_in = NS_STOP;
                  endcase
               end
            end
            PH_SEEK2, PH_TOK2: begin
               if (c == CH_COMMA) begin
                  if (ph_ff == PH_TOK2) ph_in = PH_DONE;
               end else begin
                  ph_in = PH_TOK2;
                  unique case (ns2_ff)
                     NS_LEAD: begin
                        if (c == CH_SPACE) ns2_in = NS_LEAD;
                        else if (c == CH_PLUS || c == CH_MINUS) begin
                           neg2_in = c == CH_MINUS; ns2_in = NS_INT;
                        end else if (dig) begin
                           spd_in = 16'(smul); ns2_in = NS_INT;
                        end else ns2_in = NS_STOP;
                     end
                     NS_INT: begin
                        if (dig) spd_in = (smul > 20'd32768) ? 16'd32768 : 16'(smul);
                        else ns2_in = NS_STOP;
                     end
                     default: ns2_in = NS_STOP;
                  endcase
               end
            end
            default: ph_in = PH_DONE;
         endcase
         // profile argument is the raw text after the colon
         if (in_args) begin
            if (pcnt_ff == 3'd0) begin
               plin_in = c == "L"; psin_in = c == "S";
            end else if (pcnt_ff == 3'd1) begin
               plin_in = plin_ff && c == "I"; psin_in = psin_ff && c == "I";
            end else if (pcnt_ff == 3'd2) begin
               plin_in = plin_ff && c == "N"; psin_in = psin_ff && c == "N";
            end else begin
               pover_in = 1'b1;
            end
            if (pcnt_ff != 3'd3) pcnt_in = pcnt_ff + 3'd1;
         end
      end else begin
         klen_in = '0;  klong_in = 1'b0; ph_in = PH_KEY;
         ns1_in = NS_LEAD; ns2_in = NS_LEAD; neg1_in = 1'b0; neg2_in = 1'b0;
         whole_in = '0; frac_in = '0; spd_in = '0; fwd_in = 1'b0;
         pcnt_in = '0; plin_in = 1'b0; psin_in = 1'b0; pover_in = 1'b0;
      end
   end

   // result at the end of a line
   always_comb begin
      centi  = 24'(whole_ff) * 24'd100 + 24'(frac_ff);
      sp_mag = neg2_ff ? -17'(spd_ff) :
               ((spd_ff > 16'd32767) ? 17'd32767 : 17'(spd_ff));
      if (neg1_ff) dist_val = (centi > 24'd8388608) ? 24'h800000 : -centi;
      else dist_val = (centi > 24'd8388607) ? 24'h7FFFFF : centi;
      fire = 1'b0;
      res  = '0;
      if (ev_data.kind == EV_EOL) begin
         fire = 1'b1;
         if (k_ping) res.command = CMD_PING;
         else if (k_cal) res.command = CMD_CAL;
         else if (k_home) res.command = CMD_HOME;
         else if (k_jstop) res.command = CMD_JSTOP;
         else if (k_stop) res.command = CMD_STOP;
         else if (k_estop) res.command = CMD_ESTOP;
         else if (k_eclr) res.command = CMD_ECLR;
         else if (!in_args) fire = 1'b0;
         else if ((k_jog || k_move) &&
                  (ph_ff == PH_TOK2 || ph_ff == PH_DONE)) begin
            res.speed_value = sp_mag[15:0];
            if (k_jog) begin
               res.command = CMD_JOG; res.jog_forward = fwd_ff;
            end else begin
               res.command = CMD_MOVE; res.distance_centi_cm = dist_val;
            end
         end else if (k_prof) begin
            res.command = CMD_PROFILE;
            if (pcnt_ff == 3'd3 && !pover_ff && plin_ff) res.profile_select = PROF_LIN;
            else if (pcnt_ff == 3'd3 && !pover_ff && psin_ff) res.profile_select = PROF_SIN;
            else res.profile_select = PROF_TRAP;
         end else fire = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < 8; i++) key_ff[i] <= key_in[i];
      end
      if (take && fire) out_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= '0; klong_ff <= 1'b0; ph_ff <= PH_KEY;
         ns1_ff <= NS_LEAD; ns2_ff <= NS_LEAD;
         whole_ff <= '0; frac_ff <= '0; spd_ff <= '0;
         fwd_ff <= 1'b0; neg1_ff <= 1'b0; neg2_ff <= 1'b0;
         plin_ff <= 1'b0; psin_ff <= 1'b0;
         pcnt_ff <= '0; pover_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         if (take) begin
            klen_ff <= klen_in; klong_ff <= klong_in; ph_ff <= ph_in;
            ns1_ff <= ns1_in;   ns2_ff <= ns2_in;
            whole_ff <= whole_in; frac_ff <= frac_in; spd_ff <= spd_in;
            fwd_ff <= fwd_in;     neg1_ff <= neg1_in; neg2_ff <= neg2_in;
            plin_ff <= plin_in;   psin_ff <= psin_in;
            pcnt_ff <= pcnt_in; pover_ff <= pover_in;
         end
         if (take && fire) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
   end

endmodule

// ===== rtl/core/serial_command_line_decoder.sv =====
// top level of the serial command line decoder
//  channel | dir | tdata fields (low bit up)
//  req_    | in  | rx_byte[7:0]
//  rsp_    | out | command[3:0] jog_forward[4] speed_value[20:5]
//          |     | distance_centi_cm[44:21] profile_select[46:45] zero pad
// one received byte per cycle is accepted back to back; the front end
// classifies each byte against the running line length, a two-entry queue
// decouples it from the back end, which parses the line as it arrives and
// sets the command at the newline, registering rsp_tvalid. a result waits
// in its register while later bytes keep flowing; only a second completed
// command meeting a waiting result stalls the back end, and once the queue
// is full req_tready drops. reset is synchronous and clears line length,
// parse state and valids.
module serial_command_line_decoder #(
   parameter int unsigned LINE_CAP = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // command, jog_forward, speed, distance, profile
);
   import scld_pkg::*;

   // classified items from the front end
   logic    fe_valid, fe_ready;
   ev_type  fe_data;
   // queue output toward the parser
   logic    q_valid, q_ready;
   ev_type  q_data;
   rsp_type rsp;

   scld_front #(.LINE_CAP(LINE_CAP)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_byte(req_tdata),
      .ev_valid(fe_valid), .ev_ready(fe_ready), .ev_data(fe_data)
   );

   scld_fifo #(.WIDTH($bits(ev_type))) u_fifo (
      .clock(clock), .reset(reset),
      .wr_valid(fe_valid), .wr_ready(fe_ready), .wr_data(fe_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
   );

   scld_back u_back (
      .clock(clock), .reset(reset),
      .ev_valid(q_valid), .ev_ready(q_ready), .ev_data(q_data),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_data(rsp)
   );

   // pack result fields, highest first, command in the lowest bits
   assign rsp_tdata = {1'b0, rsp.profile_select, rsp.distance_centi_cm,
                       rsp.speed_value, rsp.jog_forward, rsp.command};

endmodule

// ===== bench/tb_serial_command_line_decoder.sv =====
// testbench for the serial command line decoder: byte stream in, decoded commands checked
`timescale 1ns / 1ps

module tb_serial_command_line_decoder;
   import scld_pkg::*;

   localparam int LineCap = 64;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // rx_byte[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // command[3:0] jog_forward[4] speed[20:5] distance[44:21] profile[46:45]

   // predictor state: the line held so far
   byte unsigned held_line[LineCap];
   int           held_len;

   rsp_type pending_cmds[$];
   int      mismatch_count = 0;
   bit      rx_stall_en;

   serial_command_line_decoder #(.LINE_CAP(LineCap)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // exact match of held_line[b..e) against a word
   function automatic bit span_equals(int b, int e, string word);
      int i;
      if (e - b != word.len()) return 0;
      for (i = 0; i < word.len(); i++)
         if (held_line[b+i] != word[i]) return 0;
      return 1;
   endfunction

   // next comma token, runs of empty fields skipped
   function automatic bit next_token(inout int pos, output int b, output int e);
      int i;
      i = pos;
      b = 0;
      e = 0;
      while (i < held_len && held_line[i] == CH_COMMA) i++;
      if (i >= held_len) return 0;
      b = i;
      while (i < held_len && held_line[i] != CH_COMMA) i++;
      e = i;
      if (i < held_len) i++;
      pos = i;
      return 1;
   endfunction

   function automatic int skip_spaces_sign(int i, int e, output bit neg);
      neg = 0;
      while (i < e && held_line[i] == CH_SPACE) i++;
      if (i < e && (held_line[i] == CH_PLUS || held_line[i] == CH_MINUS)) begin
         neg = (held_line[i] == CH_MINUS);
         i++;
      end
      return i;
   endfunction

   function automatic logic [SpdW-1:0] speed_of(int b, int e);
      bit          neg;
      int          i;
      int unsigned acc;
      acc = 0;
      i = skip_spaces_sign(b, e, neg);
      while (i < e && is_digit(held_line[i])) begin
         acc = acc * 10 + (held_line[i] - 8'h30);
         if (acc > 32768) acc = 32768;
         i++;
      end
      if (neg) return SpdW'(-int'(acc));
      return (acc > 32767) ? 16'h7FFF : SpdW'(acc);
   endfunction

   function automatic logic [DistW-1:0] centi_of(int b, int e);
      bit          neg;
      int          i, k;
      int unsigned whole, frac, centi;
      whole = 0;
      frac = 0;
      i = skip_spaces_sign(b, e, neg);
      while (i < e && is_digit(held_line[i])) begin
         whole = whole * 10 + (held_line[i] - 8'h30);
         if (whole > 100000) whole = 100000;
         i++;
      end
      if (i < e && held_line[i] == CH_DOT) begin
         i++;
         for (k = 0; k < 2; k++) begin
            frac = frac * 10;
            if (i < e && is_digit(held_line[i])) begin
               frac += held_line[i] - 8'h30;
               i++;
            end
         end
      end
      centi = whole * 100 + frac;
      if (neg) return DistW'(-int'((centi > 8388608) ? 8388608 : centi));
      return DistW'((centi > 8388607) ? 8388607 : centi);
   endfunction

   // decode the held line; returns 1 with a command when one is recognized
   function automatic bit decode_held(output rsp_type cmd);
      int    klen, pos, b1, e1, b2, e2, k;
      bit    has_args;
      string simple_words[7];
      simple_words = '{"PING", "CAL", "HOME", "JSTOP", "STOP", "ESTOP", "ECLR"};
      cmd = '0;
      klen = 0;
      while (klen < held_len && held_line[klen] != CH_COLON) klen++;
      has_args = klen < held_len;
      pos = has_args ? klen + 1 : held_len;
      for (k = 0; k < 7; k++)
         if (span_equals(0, klen, simple_words[k])) begin
            cmd.command = cmd_type'(k);
            return 1;
         end
      if (!has_args) return 0;
      if (span_equals(0, klen, "JOG") || span_equals(0, klen, "MOVE")) begin
         if (!next_token(pos, b1, e1)) return 0;
         if (!next_token(pos, b2, e2)) return 0;
         cmd.speed_value = speed_of(b2, e2);
         if (span_equals(0, klen, "JOG")) begin
            cmd.command = CMD_JOG;
            cmd.jog_forward = (held_line[b1] == CH_F);
         end else begin
            cmd.command = CMD_MOVE;
            cmd.distance_centi_cm = centi_of(b1, e1);
         end
         return 1;
      end
      if (span_equals(0, klen, "PROFILE")) begin
         cmd.command = CMD_PROFILE;
         if (span_equals(pos, held_len, "LIN")) cmd.profile_select = PROF_LIN;
         else if (span_equals(pos, held_len, "SIN")) cmd.profile_select = PROF_SIN;
         else cmd.profile_select = PROF_TRAP;
         return 1;
      end
      return 0;
   endfunction

   // advance the predicted line by one accepted byte
   function automatic void absorb_byte(byte unsigned c);
      rsp_type cmd;
      if (c == CH_NL) begin
         if (held_len > 0 && decode_held(cmd)) pending_cmds.push_back(cmd);
         held_len = 0;
      end else if (c >= CH_LO && c <= CH_HI) begin
         if (held_len < LineCap) begin
            held_line[held_len] = c;
            held_len++;
         end else begin
            held_len = 0;
         end
      end
   endfunction

   // short gap, sometimes long
   function automatic int gap_len();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 0) n = 0;
      return n;
   endfunction

   // send one byte; handshake completes at a rising edge
   task automatic send_byte(byte unsigned c);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      absorb_byte(c);
      @(negedge clock);
   endtask

   task automatic send_line(string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(CH_NL);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.command           = cmd_type'(rsp_tdata[3:0]);
         got.jog_forward       = rsp_tdata[4];
         got.speed_value       = rsp_tdata[20:5];
         got.distance_centi_cm = rsp_tdata[44:21];
         got.profile_select    = rsp_tdata[46:45];
         if (pending_cmds.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item %h", rsp_tdata);
         end else begin
            want = pending_cmds.pop_front();
            if (got !== want || rsp_tdata[47] !== 1'b0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp cmd=%0d fwd=%0d spd=%0d dist=%0d prof=%0d",
                     want.command, want.jog_forward, $signed(want.speed_value),
                     $signed(want.distance_centi_cm), want.profile_select);
                  $display("          got cmd=%0d fwd=%0d spd=%0d dist=%0d prof=%0d",
                     got.command, got.jog_forward, $signed(got.speed_value),
                     $signed(got.distance_centi_cm), got.profile_select);
               end
            end
         end
      end
   end

   // receiver stalls driven at the falling edge
   always @(negedge clock) begin
      if (!rx_stall_en) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 2) == 0) rsp_tready <= 1'b1;
   end

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic test_simple_commands();
      send_line("PING");
      send_line("CAL");
      send_line("HOME");
      send_line("JSTOP");
      send_line("STOP:ignored");
      send_line("ESTOP");
      send_line("ECLR");
      send_line("PINGX");
      send_byte(CH_NL);             // empty line does nothing
      send_line("P\rING");          // carriage return dropped
   endtask

   task automatic test_argument_commands();
      send_line("JOG:F,120");
      send_line("JOG:,,B,,-40000");
      send_line("JOG:F");           // too few tokens
      send_line("JOG");             // no colon
      send_line("MOVE:-12.345,99999");
      send_line("MOVE:+99999999.9,  -7x");
      send_line("MOVE:.5,abc");
      send_line("PROFILE:LIN");
      send_line("PROFILE:SIN");
      send_line("PROFILE:");
      send_line("PROFILE:LIN,");
      send_line("FOO:1,2");
   endtask

   task automatic test_overflow();
      int i;
      for (i = 0; i < LineCap; i++) send_byte(8'h41);
      send_byte(8'h7E);             // one past the cap empties the line
      send_line("PING");
      for (i = 0; i < LineCap - 4; i++) send_byte(8'h20);
      send_line("CAL");             // stays one byte short of the cap
   endtask

   function automatic string rand_number();
      string s;
      int    i, n;
      s = "";
      case ($urandom_range(0, 3))
         0: s = "-";
         1: s = "+";
         2: s = " ";
         default: ;
      endcase
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      for (i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      if ($urandom_range(0, 2) == 0) begin
         s = {s, "."};
         n = $urandom_range(0, 3);
         for (i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
      return s;
   endfunction

   task automatic test_random_traffic();
      string words[10];
      string s;
      int    sent, i, n;
      bit    held_off;
      words = '{"PING", "CAL", "HOME", "JSTOP", "STOP", "ESTOP", "ECLR", "JOG", "MOVE",
                "PROFILE"};
      sent = 0;
      held_off = 0;
      while (sent < 2000) begin
         if ($urandom_range(0, 9) < 7) begin
            s = words[$urandom_range(0, 9)];
            if ($urandom_range(0, 7) != 0) begin
               s = {s, ":"};
               if ($urandom_range(0, 3) == 0) s = {s, ","};
               case ($urandom_range(0, 3))
                  0: s = {s, "LIN"};
                  1: s = {s, "SIN"};
                  2: s = {s, "F"};
                  default: ;
               endcase
               s = {s, rand_number(), ",", rand_number()};
               if ($urandom_range(0, 4) == 0) s = {s, ",", rand_number()};
            end
            if ($urandom_range(0, 15) == 0) s = {s, "\r"};
            send_line(s);
            sent += s.len() + 1;
         end else begin
            // noise: every byte value is possible
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++) begin
               send_byte(8'($urandom_range(0, 255)));
               sent++;
            end
         end
         if (!held_off && sent > 1000) begin
            wait_drained();   // sender holds off once
            held_off = 1;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rx_stall_en = 1'b0;
      held_len = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_simple_commands();
      rx_stall_en = 1'b1;
      test_argument_commands();
      test_overflow();
      wait_drained();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0 && pending_cmds.size() == 0)
         $display("tb_serial_command_line_decoder: done, clean");
      else
         $display("tb_serial_command_line_decoder: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_serial_command_line_decoder: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/scld_pkg.sv
rtl/core/scld_front.sv
rtl/core/scld_fifo.sv
rtl/core/scld_back.sv
rtl/core/serial_command_line_decoder.sv
bench/tb_serial_command_line_decoder.sv
